[rtl/fsf_pkg.sv]
package fsf_pkg;

   localparam int FRAME_COUNT   = 4;
   localparam int QUEUE_DEPTH   = 2;

   localparam logic [31:0] BLANK_VALUE      = 32'hFFFF_FFFF;
   localparam logic [7:0]  BLANK_SEGMENTS   = 8'hFF;
   localparam logic [7:0]  POINT_CLEAR_MASK = 8'h7F;
   localparam logic [7:0]  NO_SELECT        = 8'hFF;

   // reciprocal of 10000 for a 32-bit dividend: q = (v * RECIP_10000) >> 45
   localparam logic [31:0] RECIP_10000 = 32'hD1B7_1759;
   localparam int          SHIFT_10000 = 45;
   localparam logic [31:0] MODULUS     = 32'd10000;

   // reciprocals for a 14-bit remainder below 10000
   localparam logic [13:0] RECIP_1000  = 14'd8389;
   localparam int          SHIFT_1000  = 23;
   localparam logic [13:0] RECIP_100   = 14'd10486;
   localparam int          SHIFT_100   = 20;
   localparam logic [13:0] RECIP_10    = 14'd13108;
   localparam int          SHIFT_10    = 17;

   // one queued request: start position and the four segment bytes
   typedef struct packed {
      logic [2:0]                  start_position;
      logic [FRAME_COUNT-1:0][7:0] segments;
   } fsf_entry_type;

   // queue status seen by the front and back
   typedef struct packed {
      logic full;
      logic head_valid;
   } fsf_q_status_type;

   // active-low common-anode patterns for decimal digits
   function automatic logic [7:0] digit_pattern(input logic [3:0] digit);
      logic [7:0] pat;
      case (digit)
         4'd0:    pat = 8'hC0;
         4'd1:    pat = 8'hF9;
         4'd2:    pat = 8'hA4;
         4'd3:    pat = 8'hB0;
         4'd4:    pat = 8'h99;
         4'd5:    pat = 8'h92;
         4'd6:    pat = 8'h82;
         4'd7:    pat = 8'hF8;
         4'd8:    pat = 8'h80;
         4'd9:    pat = 8'h90;
         default: pat = BLANK_SEGMENTS;
      endcase
      return pat;
   endfunction

   // active-low digit enable per display position; off the display selects none
   function automatic logic [7:0] select_pattern(input logic [3:0] position);
      logic [7:0] sel;
      case (position)
         4'd0:    sel = 8'hEF;
         4'd1:    sel = 8'hDF;
         4'd2:    sel = 8'hBF;
         4'd3:    sel = 8'h7F;
         4'd4:    sel = 8'hFE;
         4'd5:    sel = 8'hFD;
         4'd6:    sel = 8'hFB;
         4'd7:    sel = 8'hF7;
         default: sel = NO_SELECT;
      endcase
      return sel;
   endfunction

endpackage

[rtl/fsf_front.sv]
module fsf_front
   import fsf_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [2:0]       req_start_position,
   input  logic [31:0]      req_value,
   input  fsf_q_status_type q_status,
   output logic             push,
   output fsf_entry_type    push_entry
);

   logic        advance;

   logic        s1_valid_ff, s1_valid_in;
   logic [63:0] s1_prod_ff, s1_prod_in;
   logic [31:0] s1_value_ff;
   logic [2:0]  s1_start_ff;
   logic        s1_blank_ff;

   logic        s2_valid_ff;
   logic [13:0] s2_n_ff, s2_n_in;
   logic [2:0]  s2_start_ff;
   logic        s2_blank_ff;

   logic        s3_valid_ff;
   logic [13:0] s3_n_ff;
   logic [3:0]  s3_q1000_ff, s3_q1000_in;
   logic [6:0]  s3_q100_ff, s3_q100_in;
   logic [9:0]  s3_q10_ff, s3_q10_in;
   logic [2:0]  s3_start_ff;
   logic        s3_blank_ff;

   logic [18:0] quot;
   logic [31:0] quot_times;
   logic [31:0] rem;
   logic [27:0] p1000, p100, p10;
   logic [6:0]  d1_wide;
   logic [9:0]  d2_wide;
   logic [13:0] d3_wide;
   logic [3:0]  d0, d1, d2, d3;
   logic [FRAME_COUNT-1:0][7:0] seg;

   // the whole pipe moves unless the last stage holds a request the queue cannot take
   assign advance   = !s3_valid_ff || !q_status.full;
   assign req_stall = !advance;
   assign push      = s3_valid_ff && !q_status.full;

   // stage 1: multiply by the reciprocal of 10000
   assign s1_valid_in = req_valid;
   assign s1_prod_in  = 64'(req_value) * 64'(RECIP_10000);

   // stage 2: remainder modulo 10000
   assign quot       = s1_prod_ff[SHIFT_10000 +: 19];
   assign quot_times = 32'(quot) * MODULUS;
   assign rem        = s1_value_ff - quot_times;
   assign s2_n_in    = rem[13:0];

   // stage 3: quotients by 1000, 100 and 10
   assign p1000       = 28'(s2_n_ff) * 28'(RECIP_1000);
   assign p100        = 28'(s2_n_ff) * 28'(RECIP_100);
   assign p10         = 28'(s2_n_ff) * 28'(RECIP_10);
   assign s3_q1000_in = p1000[SHIFT_1000 +: 4];
   assign s3_q100_in  = p100[SHIFT_100 +: 7];
   assign s3_q10_in   = p10[SHIFT_10 +: 10];

   // digits from the quotients, times ten as shift and add
   assign d1_wide = s3_q100_ff - ((7'(s3_q1000_ff) << 3) + (7'(s3_q1000_ff) << 1));
   assign d2_wide = s3_q10_ff - ((10'(s3_q100_ff) << 3) + (10'(s3_q100_ff) << 1));
   assign d3_wide = s3_n_ff - ((14'(s3_q10_ff) << 3) + (14'(s3_q10_ff) << 1));
   assign d0 = s3_q1000_ff;
   assign d1 = d1_wide[3:0];
   assign d2 = d2_wide[3:0];
   assign d3 = d3_wide[3:0];

   // segment bytes with leading blank and decimal point
   always_comb begin
      seg = '{default: BLANK_SEGMENTS};
      if (!s3_blank_ff) begin
         seg[0] = (s3_start_ff != 3'd0 && d0 == 4'd0) ? BLANK_SEGMENTS : digit_pattern(d0);
         seg[1] = digit_pattern(d1);
         seg[2] = digit_pattern(d2);
         seg[3] = digit_pattern(d3);
         if (s3_start_ff == 3'd0) begin
            seg[0] = seg[0] & POINT_CLEAR_MASK;
         end else begin
            seg[1] = seg[1] & POINT_CLEAR_MASK;
         end
      end
   end

   assign push_entry.start_position = s3_start_ff;
   assign push_entry.segments       = seg;

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_prod_ff  <= s1_prod_in;
         s1_value_ff <= req_value;
         s1_start_ff <= req_start_position;
         s1_blank_ff <= (req_value == BLANK_VALUE);
         s2_n_ff     <= s2_n_in;
         s2_start_ff <= s1_start_ff;
         s2_blank_ff <= s1_blank_ff;
         s3_n_ff     <= s2_n_ff;
         s3_q1000_ff <= s3_q1000_in;
         s3_q100_ff  <= s3_q100_in;
         s3_q10_ff   <= s3_q10_in;
         s3_start_ff <= s2_start_ff;
         s3_blank_ff <= s2_blank_ff;
      end
   end

endmodule

[rtl/fsf_queue.sv]
module fsf_queue
   import fsf_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  fsf_entry_type    push_entry,
   input  logic             pop,
   output fsf_entry_type    head_entry,
   output fsf_q_status_type q_status
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

   fsf_entry_type    entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign q_status.full       = (count_ff == FULL_CNT);
   assign q_status.head_valid = (count_ff != '0);
   assign head_entry          = entry_ff[rd_ptr_ff];

   assign do_push = push && !q_status.full;
   assign do_pop  = pop && q_status.head_valid;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[rtl/fsf_back.sv]
module fsf_back
   import fsf_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  fsf_q_status_type q_status,
   input  fsf_entry_type    head_entry,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [7:0]       rsp_digit_select,
   output logic [7:0]       rsp_segments,
   output logic             rsp_last_digit
);

   localparam int FRAME_W = $clog2(FRAME_COUNT);
   localparam logic [FRAME_W-1:0] LAST_FRAME = FRAME_W'(FRAME_COUNT - 1);

   logic [FRAME_W-1:0] frame_ff, frame_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         digit_select_ff, digit_select_in;
   logic [7:0]         segments_ff, segments_in;
   logic               last_digit_ff, last_digit_in;
   logic               load;
   logic               emit;
   logic [3:0]         position;

   // output register takes a new frame when empty or being taken
   assign load = !rsp_valid_ff || !rsp_stall;
   assign emit = load && q_status.head_valid;
   assign pop  = emit && (frame_ff == LAST_FRAME);

   assign position = 4'(head_entry.start_position) + 4'(frame_ff);

   always_comb begin
      frame_in        = frame_ff;
      rsp_valid_in    = rsp_valid_ff;
      digit_select_in = digit_select_ff;
      segments_in     = segments_ff;
      last_digit_in   = last_digit_ff;
      if (load) begin
         rsp_valid_in = q_status.head_valid;
      end
      if (emit) begin
         frame_in        = (frame_ff == LAST_FRAME) ? '0 : frame_ff + FRAME_W'(1);
         digit_select_in = select_pattern(position);
         segments_in     = head_entry.segments[frame_ff];
         last_digit_in   = (frame_ff == LAST_FRAME);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         frame_ff     <= frame_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      digit_select_ff <= digit_select_in;
      segments_ff     <= segments_in;
      last_digit_ff   <= last_digit_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_digit_select = digit_select_ff;
   assign rsp_segments     = segments_ff;
   assign rsp_last_digit   = last_digit_ff;

endmodule

[rtl/four_digit_segment_formatter.sv]
// A taken request passes front stages s1, s2, s3, the queue and the output register
// before the first of its four frames appears; the other three follow unless stalled.
// Throughput: the frame sequencer drives one frame a cycle while not stalled, four
// per request; the three-stage front and two-entry queue absorb short bursts.
// Reset (synchronous, active high) empties the pipe, the queue and the output.
module four_digit_segment_formatter
   import fsf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_start_position,
   input  logic [31:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_digit_select,
   output logic [7:0]  rsp_segments,
   output logic        rsp_last_digit
);

   fsf_q_status_type q_status;
   fsf_entry_type    push_entry;
   fsf_entry_type    head_entry;
   logic             push;
   logic             pop;

   // digit split and segment coding
   fsf_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_start_position (req_start_position),
      .req_value          (req_value),
      .q_status           (q_status),
      .push               (push),
      .push_entry         (push_entry)
   );

   // decoupling queue
   fsf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .q_status   (q_status)
   );

   // frame sequencer
   fsf_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_status         (q_status),
      .head_entry       (head_entry),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_digit_select (rsp_digit_select),
      .rsp_segments     (rsp_segments),
      .rsp_last_digit   (rsp_last_digit)
   );

endmodule
